>>> src/ssd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the seven-segment serial driver.
// No dependencies; used by ssd_front, ssd_back and the top level.
package ssd_pkg;

   // One shift register frame: inverted segments high, digit select low
   localparam int FRAME_BITS = 16;
   localparam int SEL_BITS   = 8;

   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [SEL_BITS-1:0]   byte_type;
   typedef logic [3:0]            bcd_type;
   typedef logic [13:0]           mag_type;

   // Request modes
   localparam logic MODE_NUMBER = 1'b0;
   localparam logic MODE_DIGIT  = 1'b1;

   // Display limits and special patterns
   localparam logic signed [31:0] MAX_SHOWN     = 32'sd9999;
   localparam logic signed [31:0] MIN_SHOWN     = -32'sd999;
   localparam byte_type           MINUS_PATTERN = 8'h40;
   localparam byte_type           SEL_ONE       = 8'h01;
   localparam byte_type           BYTE_ONES     = 8'hFF;
   localparam logic [7:0]         MAX_DIGIT     = 8'd9;
   localparam logic [2:0]         MAX_POSITION  = 3'd3;

   typedef struct packed {
      bcd_type digit;
      mag_type rest;
   } split_type;

   // Segment pattern (bit 6..0 = g..a) for a decimal digit
   function automatic byte_type glyph(input bcd_type d);
      byte_type pat;
      case (d)
         4'd0:    pat = 8'h3F;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5B;
         4'd3:    pat = 8'h4F;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6D;
         4'd6:    pat = 8'h7D;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7F;
         4'd9:    pat = 8'h6F;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   // One decimal digit off the top: value must be below 10*weight.
   // Nine independent compares against constant multiples, then a select.
   function automatic split_type split_digit(input mag_type value, input mag_type weight);
      split_type res;
      mag_type   step;
      res.digit = 4'd0;
      res.rest  = value;
      for (int k = 1; k <= 9; k++) begin
         step = mag_type'(k * int'(weight));
         if (value >= step) begin
            res.digit = bcd_type'(k);
            res.rest  = value - step;
         end
      end
      return res;
   endfunction

endpackage

>>> src/ssd_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, saturates and splits the number into digits
// over three pipeline stages and builds the display frames. Uses ssd_pkg.
module ssd_front #(
   parameter int NUM_DIGITS = 4,
   parameter int IDX_WIDTH  = 2
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_mode,
   input  logic signed [31:0]                       req_number,
   input  logic [7:0]                               req_digit,
   input  logic [2:0]                               req_position,
   output logic                                     push_valid,
   input  logic                                     push_ready,
   output logic [NUM_DIGITS-1:0][ssd_pkg::FRAME_BITS-1:0] push_frames,
   output logic [IDX_WIDTH-1:0]                     push_last_idx
);

   // Stage 1: saturated magnitude and sign
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_mode_ff, s1_neg_ff;
   ssd_pkg::mag_type  s1_mag_ff;
   logic [7:0]        s1_digit_ff;
   logic [2:0]        s1_pos_ff;
   // Stage 2: thousands digit and remainder
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_mode_ff, s2_neg_ff;
   ssd_pkg::bcd_type  s2_thou_ff;
   ssd_pkg::mag_type  s2_rest_ff;
   logic [7:0]        s2_digit_ff;
   logic [2:0]        s2_pos_ff;
   // Stage 3: all four digits
   logic              s3_valid_ff, s3_valid_in;
   logic              s3_mode_ff, s3_neg_ff;
   ssd_pkg::bcd_type  s3_digs_ff [4];
   logic [7:0]        s3_digit_ff;
   logic [2:0]        s3_pos_ff;

   logic                   s1_ready, s2_ready, s3_ready;
   logic signed [31:0]     sat_value, abs_value;
   ssd_pkg::split_type     thou_split, hund_split, tens_split;
   ssd_pkg::byte_type      one_sel, one_pat;
   logic                   one_blank;

   // Elastic stage handshakes
   assign s3_ready  = !s3_valid_ff || push_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign s1_valid_in = s1_ready ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Saturate to the displayable range and take the magnitude
   always_comb begin
      if (req_number > ssd_pkg::MAX_SHOWN) begin
         sat_value = ssd_pkg::MAX_SHOWN;
      end else if (req_number < ssd_pkg::MIN_SHOWN) begin
         sat_value = ssd_pkg::MIN_SHOWN;
      end else begin
         sat_value = req_number;
      end
      abs_value = sat_value[31] ? (32'sd0 - sat_value) : sat_value;
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_mode_ff  <= req_mode;
         s1_neg_ff   <= sat_value[31];
         s1_mag_ff   <= abs_value[13:0];
         s1_digit_ff <= req_digit;
         s1_pos_ff   <= req_position;
      end
   end

   // Thousands
   assign thou_split = ssd_pkg::split_digit(s1_mag_ff, 14'd1000);

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_thou_ff  <= thou_split.digit;
         s2_rest_ff  <= thou_split.rest;
         s2_digit_ff <= s1_digit_ff;
         s2_pos_ff   <= s1_pos_ff;
      end
   end

   // Hundreds, then tens and ones from a remainder below 1000
   assign hund_split = ssd_pkg::split_digit(s2_rest_ff, 14'd100);
   assign tens_split = ssd_pkg::split_digit(hund_split.rest, 14'd10);

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_mode_ff    <= s2_mode_ff;
         s3_neg_ff     <= s2_neg_ff;
         s3_digs_ff[0] <= s2_thou_ff;
         s3_digs_ff[1] <= hund_split.digit;
         s3_digs_ff[2] <= tens_split.digit;
         s3_digs_ff[3] <= tens_split.rest[3:0];
         s3_digit_ff   <= s2_digit_ff;
         s3_pos_ff     <= s2_pos_ff;
      end
   end

   // Single digit frame: blank segments and inverted select when out of range
   assign one_sel   = ssd_pkg::SEL_ONE << s3_pos_ff;
   assign one_blank = (s3_digit_ff > ssd_pkg::MAX_DIGIT) ||
                      (s3_pos_ff > ssd_pkg::MAX_POSITION);
   assign one_pat   = ssd_pkg::glyph(s3_digit_ff[3:0]);

   // Frame build
   always_comb begin
      ssd_pkg::byte_type pat;
      for (int p = 0; p < NUM_DIGITS; p++) begin
         if (p == 0 && s3_neg_ff) begin
            pat = ssd_pkg::MINUS_PATTERN;
         end else begin
            pat = ssd_pkg::glyph(s3_digs_ff[p]);
         end
         push_frames[p] = {~pat, ssd_pkg::byte_type'(ssd_pkg::SEL_ONE << p)};
      end
      if (s3_mode_ff == ssd_pkg::MODE_DIGIT) begin
         if (one_blank) begin
            push_frames[0] = {ssd_pkg::BYTE_ONES, ~one_sel};
         end else begin
            push_frames[0] = {~one_pat, one_sel};
         end
         push_last_idx = '0;
      end else begin
         push_last_idx = IDX_WIDTH'(NUM_DIGITS - 1);
      end
   end

   assign push_valid = s3_valid_ff;

endmodule

>>> src/ssd_queue.sv
`timescale 1ns / 1ps
// Two-entry queue that decouples frame building from serial output.
// Generic data; no package dependency.
module ssd_queue #(
   parameter int DATA_WIDTH = 66
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  head_valid,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] head_data
);

   logic [DATA_WIDTH-1:0] entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue popped while empty");
   // Fill count follows pushes and pops
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count did not advance on push");
   assert property (@(posedge clock) disable iff (reset)
                    (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("queue count did not drop on pop");

endmodule

>>> src/ssd_back.sv
`timescale 1ns / 1ps
// Back end: shifts queued frames out one bit per beat, MSB first, with latch
// on bit sixteen and last on the final bit of a request. Uses ssd_pkg.
module ssd_back #(
   parameter int NUM_DIGITS = 4,
   parameter int IDX_WIDTH  = 2
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     head_valid,
   input  logic [NUM_DIGITS-1:0][ssd_pkg::FRAME_BITS-1:0] head_frames,
   input  logic [IDX_WIDTH-1:0]                     head_last_idx,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_serial_bit,
   output logic                                     rsp_latch,
   output logic                                     rsp_last
);

   localparam int BIT_WIDTH = $clog2(ssd_pkg::FRAME_BITS);

   logic [BIT_WIDTH-1:0] bit_ff, bit_in;
   logic [IDX_WIDTH-1:0] frame_ff, frame_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_bit_ff, rsp_latch_ff, rsp_last_ff;
   ssd_pkg::frame_type   cur_frame;
   logic                 advance, frame_end, item_end;

   // Output register takes a new beat when empty or being drained
   assign advance   = head_valid && (!rsp_valid_ff || rsp_ready);
   assign cur_frame = head_frames[frame_ff];
   assign frame_end = (bit_ff == BIT_WIDTH'(ssd_pkg::FRAME_BITS - 1));
   assign item_end  = frame_end && (frame_ff == head_last_idx);
   assign pop       = advance && item_end;

   // Bit and frame counters
   always_comb begin
      bit_in       = bit_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         bit_in       = bit_ff + 1'b1;
         rsp_valid_in = 1'b1;
         if (item_end) begin
            frame_in = '0;
         end else if (frame_end) begin
            frame_in = frame_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff       <= '0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bit_ff       <= bit_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output beat; MSB first, so bit index is the inverted count
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_bit_ff   <= cur_frame[~bit_ff];
         rsp_latch_ff <= frame_end;
         rsp_last_ff  <= item_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_serial_bit = rsp_bit_ff;
   assign rsp_latch      = rsp_latch_ff;
   assign rsp_last       = rsp_last_ff;

   // Last beat of a request always closes a frame
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_last_ff) |-> rsp_latch_ff)
      else $error("last beat without latch");
   // A latch beat leaves the bit counter at the start of the next frame
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_latch_ff) |-> (bit_ff == '0))
      else $error("bit counter out of step with latch");
   // After the last beat the frame index is back at the first frame
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_last_ff) |-> (frame_ff == '0))
      else $error("frame index not rewound after last beat");

endmodule

>>> src/seven_segment_serial_display_driver_core.sv
`timescale 1ns / 1ps
// A request passes the front stages and the queue before its first serial beat is registered.
// Throughput: one serial bit per cycle while rsp_ready is high, set by the bit shifter; a
// whole-number request shifts out NUM_DIGITS 16-bit frames, a single-digit request one.
// Requests are taken every cycle while the 3-stage front pipe and 2-entry queue have room.
// Reset (synchronous, active high) empties the pipe, the queue and the output beat.
module seven_segment_serial_display_driver_core #(
   parameter int NUM_DIGITS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic signed [31:0] req_number,
   input  logic [7:0]         req_digit,
   input  logic [2:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_serial_bit,
   output logic               rsp_latch,
   output logic               rsp_last
);

   localparam int IDX_WIDTH  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int DATA_WIDTH = NUM_DIGITS * ssd_pkg::FRAME_BITS + IDX_WIDTH;

   logic                                            push_valid, push_ready;
   logic [NUM_DIGITS-1:0][ssd_pkg::FRAME_BITS-1:0]  push_frames, head_frames;
   logic [IDX_WIDTH-1:0]                            push_last_idx, head_last_idx;
   logic                                            head_valid, pop;

   ssd_front #(
      .NUM_DIGITS (NUM_DIGITS),
      .IDX_WIDTH  (IDX_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_number    (req_number),
      .req_digit     (req_digit),
      .req_position  (req_position),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_frames   (push_frames),
      .push_last_idx (push_last_idx)
   );

   ssd_queue #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_last_idx, push_frames}),
      .head_valid (head_valid),
      .pop        (pop),
      .head_data  ({head_last_idx, head_frames})
   );

   ssd_back #(
      .NUM_DIGITS (NUM_DIGITS),
      .IDX_WIDTH  (IDX_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_frames    (head_frames),
      .head_last_idx  (head_last_idx),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_serial_bit (rsp_serial_bit),
      .rsp_latch      (rsp_latch),
      .rsp_last       (rsp_last)
   );

endmodule
